@@ rtl/dual_button_debounce_repeat_assert.svh @@
// assertion macros for the dual button debounce checker
// expects clk and rst_n in the scope of use
`ifndef DUAL_BUTTON_DEBOUNCE_REPEAT_ASSERT_SVH
`define DUAL_BUTTON_DEBOUNCE_REPEAT_ASSERT_SVH

// same-cycle implication
`define DBR_ASSERT_IMP(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error("dbr checker: same-cycle implication failed");

// next-cycle implication
`define DBR_ASSERT_NXT(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error("dbr checker: next-cycle implication failed");

`endif

@@ rtl/dbr_pkg.sv @@
// shared types and constants for the dual button debounce block
// no dependencies
package dbr_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 1'b1;

    localparam logic [TIME_W-1:0] SHORT_WINDOW_RST = 32'd20000;
    localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RST = 32'd500000;

    typedef enum logic [1:0] {
        PH_LONG_OFF  = 2'd0,
        PH_SHORT_ON  = 2'd1,
        PH_LONG_ON   = 2'd2,
        PH_SHORT_OFF = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [TIME_W-1:0]   deadline;
    } lane_state_t;

    typedef struct packed {
        lane_state_t st;
        logic        click;
    } lane_res_t;

endpackage

@@ rtl/dbr_if.sv @@
// valid/ready channel interfaces for sample input and click output
// depends on dbr_pkg
interface dbr_in_if;
    logic                      valid;
    logic                      ready;
    logic                      left_level;
    logic                      right_level;
    logic [dbr_pkg::TIME_W-1:0] now_us;

    modport source (output valid, output left_level, output right_level, output now_us,
                    input ready);
    modport sink (input valid, input left_level, input right_level, input now_us,
                  output ready);
endinterface

interface dbr_out_if;
    logic valid;
    logic ready;
    logic left_click;
    logic right_click;

    modport source (output valid, output left_click, output right_click, input ready);
    modport sink (input valid, input left_click, input right_click, output ready);
endinterface

@@ rtl/dual_button_debounce_repeat.sv @@
// Dual button debounce with auto-repeat. Each accepted sample (two active-low
// pin levels and a microsecond timestamp) yields one result transaction with a
// click flag per button, registered at acceptance. A new sample is taken every
// cycle as long as the output register is empty or being drained; the per-button
// deadline compare and add plus the chord merge are combinational logic.
// Configuration: index 0 sets the debounce window, index 1 the repeat interval.
// Depends on dbr_pkg, dbr_if, dbr_lane and dbr_merge.
module dual_button_debounce_repeat (
    input  logic                             clk,
    input  logic                             rst_n,
    dbr_in_if.sink                           in_ch,
    dbr_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [dbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dbr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [dbr_pkg::TIME_W-1:0] short_window_reg;
    logic [dbr_pkg::TIME_W-1:0] repeat_interval_reg;
    dbr_pkg::lane_state_t left_reg;
    dbr_pkg::lane_state_t right_reg;
    logic out_valid_reg;
    logic left_click_reg;
    logic right_click_reg;

    dbr_pkg::lane_res_t left_lane;
    dbr_pkg::lane_res_t right_lane;
    dbr_pkg::lane_res_t left_next;
    dbr_pkg::lane_res_t right_next;
    logic accept;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    dbr_lane u_left (
        .cur             (left_reg),
        .pressed         (!in_ch.left_level),
        .now_us          (in_ch.now_us),
        .short_window    (short_window_reg),
        .repeat_interval (repeat_interval_reg),
        .res             (left_lane)
    );

    dbr_lane u_right (
        .cur             (right_reg),
        .pressed         (!in_ch.right_level),
        .now_us          (in_ch.now_us),
        .short_window    (short_window_reg),
        .repeat_interval (repeat_interval_reg),
        .res             (right_lane)
    );

    dbr_merge u_merge (
        .left_in   (left_lane),
        .right_in  (right_lane),
        .left_out  (left_next),
        .right_out (right_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_window_reg    <= dbr_pkg::SHORT_WINDOW_RST;
            repeat_interval_reg <= dbr_pkg::REPEAT_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dbr_pkg::CFG_SHORT_WINDOW:    short_window_reg    <= cfg_data;
                dbr_pkg::CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                default:                      short_window_reg    <= short_window_reg;
            endcase
        end
    end

    // lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '{phase: dbr_pkg::PH_LONG_OFF, deadline: '0};
            right_reg <= '{phase: dbr_pkg::PH_LONG_OFF, deadline: '0};
        end
        else if (accept)
        begin
            left_reg  <= left_next.st;
            right_reg <= right_next.st;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_click_reg  <= left_next.click;
            right_click_reg <= right_next.click;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.left_click  = left_click_reg;
    assign out_ch.right_click = right_click_reg;

endmodule

@@ rtl/dbr_lane.sv @@
// one button lane: phase and deadline update for a single sample
// depends on dbr_pkg
module dbr_lane (
    input  dbr_pkg::lane_state_t        cur,
    input  logic                        pressed,
    input  logic [dbr_pkg::TIME_W-1:0]  now_us,
    input  logic [dbr_pkg::TIME_W-1:0]  short_window,
    input  logic [dbr_pkg::TIME_W-1:0]  repeat_interval,
    output dbr_pkg::lane_res_t          res
);

    logic expired;
    logic [dbr_pkg::TIME_W-1:0] short_dl;
    logic [dbr_pkg::TIME_W-1:0] repeat_dl;

    assign expired   = cur.deadline < now_us;
    assign short_dl  = now_us + short_window;
    assign repeat_dl = now_us + repeat_interval;

    always_comb
    begin
        res.st    = cur;
        res.click = 1'b0;
        unique case (cur.phase)
            dbr_pkg::PH_LONG_OFF:
            begin
                if (pressed)
                begin
                    res.st.phase    = dbr_pkg::PH_SHORT_ON;
                    res.st.deadline = short_dl;
                end
            end
            dbr_pkg::PH_SHORT_ON:
            begin
                if (expired)
                begin
                    res.click       = 1'b1;
                    res.st.phase    = dbr_pkg::PH_LONG_ON;
                    res.st.deadline = repeat_dl;
                end
            end
            dbr_pkg::PH_LONG_ON:
            begin
                if (!pressed)
                begin
                    res.st.phase    = dbr_pkg::PH_SHORT_OFF;
                    res.st.deadline = short_dl;
                end
                else if (expired)
                begin
                    res.click       = 1'b1;
                    res.st.deadline = repeat_dl;
                end
            end
            dbr_pkg::PH_SHORT_OFF:
            begin
                if (expired)
                begin
                    res.st.phase = dbr_pkg::PH_LONG_OFF;
                end
            end
            default:
            begin
                res.st = cur;
            end
        endcase
    end

endmodule

@@ rtl/dbr_merge.sv @@
// chord merge of the two lane results, left checked before right
// depends on dbr_pkg
module dbr_merge (
    input  dbr_pkg::lane_res_t left_in,
    input  dbr_pkg::lane_res_t right_in,
    output dbr_pkg::lane_res_t left_out,
    output dbr_pkg::lane_res_t right_out
);

    dbr_pkg::lane_res_t right_mid;

    always_comb
    begin
        right_mid = right_in;
        if (left_in.click && right_in.st.phase == dbr_pkg::PH_SHORT_ON)
        begin
            right_mid.st    = left_in.st;
            right_mid.click = 1'b1;
        end

        left_out = left_in;
        if (right_mid.click && left_in.st.phase == dbr_pkg::PH_SHORT_ON)
        begin
            left_out.st    = right_mid.st;
            left_out.click = 1'b1;
        end
        right_out = right_mid;
    end

endmodule

@@ rtl/dbr_checker.sv @@
// port-level checker for the dual button debounce block, bound to the top level
// depends on dual_button_debounce_repeat_assert.svh
`include "dual_button_debounce_repeat_assert.svh"

module dbr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic left_click,
    input logic right_click
);

    // stalled result holds
    `DBR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_click) && $stable(right_click))
    // every accepted sample shows a result next cycle
    `DBR_ASSERT_NXT(a_result_follows, in_valid && in_ready, out_valid)
    // full and stalled output blocks input
    `DBR_ASSERT_IMP(a_full_stalls, out_valid && !out_ready, !in_ready)
    // empty output never blocks input
    `DBR_ASSERT_IMP(a_empty_ready, !out_valid, in_ready)

endmodule

bind dual_button_debounce_repeat dbr_checker u_dbr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .left_click  (out_ch.left_click),
    .right_click (out_ch.right_click)
);
